/* src/dwb_pkg.sv */
package dwb_pkg;

	// default raster size
	localparam int IMAGE_WIDTH_DEF  = 640;
	localparam int IMAGE_HEIGHT_DEF = 480;

	// item field widths
	localparam int ADDR_W  = 19;
	localparam int TEXEL_W = 32;
	localparam int OX_W    = 10;
	localparam int OY_W    = 9;
	localparam int DISP_W  = 8;
	localparam int FRAC_W  = 3;

	// signed source coordinate width, wide enough for the largest compare
	localparam int CRD_W = 14;

	// 2x2 bank interleave by row and column parity
	localparam int BANKS  = 4;
	localparam int BSEL_W = 2;

	// filter arithmetic
	localparam int CHANS       = 3;
	localparam int CHAN_W      = 8;
	localparam int WGT_W       = 7;
	localparam int PROD_W      = 15;
	localparam int SUM_W       = 14;
	localparam int BLEND_SHIFT = 6;
	localparam logic [3:0] WEIGHT_ONE   = 4'h8;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// reciprocal scale for the address split
	localparam int RECIP_SHIFT = 32;

	// input tdata layout
	localparam int IN_ADDR_LSB  = 0;
	localparam int IN_VALUE_LSB = IN_ADDR_LSB + ADDR_W;
	localparam int IN_OX_LSB    = IN_VALUE_LSB + TEXEL_W;
	localparam int IN_OY_LSB    = IN_OX_LSB + OX_W;
	localparam int IN_DX_LSB    = IN_OY_LSB + OY_W;
	localparam int IN_DY_LSB    = IN_DX_LSB + DISP_W;
	localparam int IN_TDATA_W   = 88;

	// output tdata layout
	localparam int OUT_INSIDE_BIT = TEXEL_W;
	localparam int OUT_TDATA_W    = 40;

	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_RENDER = 1'b1
	} action_t;

	typedef enum logic {
		MODE_NEAREST  = 1'b0,
		MODE_BILINEAR = 1'b1
	} mode_t;

	// render control traveling beside the bank reads
	typedef struct packed {
		logic              valid;
		action_t           act;
		logic              in_range;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic              px;
		logic              py;
	} ctl_t;

	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

/* src/dwb_tex_bank.sv */
module dwb_tex_bank #(
	parameter int DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic                               we,
	input  logic [dwb_pkg::idx_w(DEPTH)-1:0]   addr,
	input  logic [dwb_pkg::TEXEL_W-1:0]        wdata,
	output logic [dwb_pkg::TEXEL_W-1:0]        rdata
);

	logic [dwb_pkg::TEXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

/* src/dwb_addr_pipe.sv */
module dwb_addr_pipe #(
	parameter int IMAGE_WIDTH  = dwb_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = dwb_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  dwb_pkg::action_t                    action,
	input  logic [dwb_pkg::ADDR_W-1:0]          texel_address,
	input  logic [dwb_pkg::TEXEL_W-1:0]         texel_value,
	input  logic [dwb_pkg::OX_W-1:0]            out_x,
	input  logic [dwb_pkg::OY_W-1:0]            out_y,
	input  logic signed [dwb_pkg::DISP_W-1:0]   disp_x,
	input  logic signed [dwb_pkg::DISP_W-1:0]   disp_y,
	output dwb_pkg::ctl_t                       ctl,
	output logic [dwb_pkg::BANKS-1:0]           bank_we,
	output logic [dwb_pkg::idx_w(((IMAGE_WIDTH + 1) / 2) * ((IMAGE_HEIGHT + 1) / 2))-1:0]
		bank_addr [dwb_pkg::BANKS],
	output logic [dwb_pkg::TEXEL_W-1:0]         bank_wdata
);

	localparam int HW         = (IMAGE_WIDTH + 1) / 2;
	localparam int HH         = (IMAGE_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HW * HH;
	localparam int BA_W       = dwb_pkg::idx_w(BANK_DEPTH);
	localparam int RIDX_W     = dwb_pkg::idx_w(HH);
	localparam int CIDX_W     = dwb_pkg::idx_w(HW);
	localparam int AW         = dwb_pkg::ADDR_W;
	localparam int PW         = AW + dwb_pkg::RECIP_SHIFT;
	localparam int CW         = dwb_pkg::CRD_W;
	localparam int FW         = dwb_pkg::FRAC_W;

	localparam logic [31:0]   TEX_DEPTH = 32'(IMAGE_WIDTH * IMAGE_HEIGHT);
	localparam logic [31:0]   RECIP     = 32'((64'd1 << dwb_pkg::RECIP_SHIFT) / IMAGE_WIDTH);
	localparam logic [AW-1:0] W_A       = AW'(IMAGE_WIDTH);
	localparam logic [BA_W-1:0] HW_BA   = BA_W'(HW);
	localparam logic signed [CW-1:0] XMAX = CW'(IMAGE_WIDTH - 1);
	localparam logic signed [CW-1:0] YMAX = CW'(IMAGE_HEIGHT - 1);

	// stage 1: captured item
	logic                         valid_s1;
	dwb_pkg::action_t             act_s1;
	logic [AW-1:0]                addr_s1;
	logic [dwb_pkg::TEXEL_W-1:0]  value_s1;
	logic [dwb_pkg::OX_W-1:0]     ox_s1;
	logic [dwb_pkg::OY_W-1:0]     oy_s1;
	logic signed [dwb_pkg::DISP_W-1:0] dx_s1;
	logic signed [dwb_pkg::DISP_W-1:0] dy_s1;

	logic [PW-1:0]                prod_recip;
	logic                         wr_ok;
	logic signed [CW-1:0]         sx;
	logic signed [CW-1:0]         sy;
	logic                         in_range;

	// stage 2: quotient estimate, source coordinate
	logic                         valid_s2;
	dwb_pkg::action_t             act_s2;
	logic                         wr_ok_s2;
	logic [AW-1:0]                addr_s2;
	logic [dwb_pkg::TEXEL_W-1:0]  value_s2;
	logic [AW-1:0]                qest_s2;
	logic signed [CW-1:0]         sx_s2;
	logic signed [CW-1:0]         sy_s2;
	logic                         inside_s2;
	logic [FW-1:0]                fx_s2;
	logic [FW-1:0]                fy_s2;

	logic [2*AW-1:0]              qw;
	logic [AW-1:0]                rest;
	logic [RIDX_W-1:0]            ry;
	logic [BA_W-1:0]              rb;

	// stage 3: remainder estimate, row base
	logic                         valid_s3;
	dwb_pkg::action_t             act_s3;
	logic                         wr_ok_s3;
	logic [dwb_pkg::TEXEL_W-1:0]  value_s3;
	logic [AW-1:0]                q_s3;
	logic [AW-1:0]                r_s3;
	logic [BA_W-1:0]              rb_s3;
	logic [CIDX_W-1:0]            cx_s3;
	logic                         px_s3;
	logic                         py_s3;
	logic                         inside_s3;
	logic [FW-1:0]                fx_s3;
	logic [FW-1:0]                fy_s3;

	logic [AW-1:0]                wrow;
	logic [AW-1:0]                wcol;
	logic [BA_W-1:0]              raddr [dwb_pkg::BANKS];

	// stage 4: bank requests
	logic                         valid_s4;
	dwb_pkg::action_t             act_s4;
	logic                         wr_ok_s4;
	logic [dwb_pkg::TEXEL_W-1:0]  value_s4;
	logic [RIDX_W-1:0]            wrow_s4;
	logic [CIDX_W-1:0]            wcol_s4;
	logic [dwb_pkg::BSEL_W-1:0]   wbank_s4;
	logic [BA_W-1:0]              raddr_s4 [dwb_pkg::BANKS];
	logic                         px_s4;
	logic                         py_s4;
	logic                         inside_s4;
	logic [FW-1:0]                fx_s4;
	logic [FW-1:0]                fy_s4;

	logic [BA_W-1:0]              waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1 logic: reciprocal product, displaced source and range test
	always_comb begin
		prod_recip = PW'(addr_s1) * PW'(RECIP);
		wr_ok      = 32'(addr_s1) < TEX_DEPTH;
		sx = CW'($signed({1'b0, ox_s1})) + CW'(dx_s1 >>> FW);
		sy = CW'($signed({1'b0, oy_s1})) + CW'(dy_s1 >>> FW);
		in_range = !sx[CW-1] && (sx < XMAX) && !sy[CW-1] && (sy < YMAX);
	end

	// stage 2 logic: remainder estimate, bank row base
	always_comb begin
		qw   = (2*AW)'(qest_s2) * (2*AW)'(W_A);
		rest = addr_s2 - qw[AW-1:0];
		ry   = RIDX_W'(sy_s2[CW-1:1]);
		rb   = BA_W'(ry) * HW_BA;
	end

	// stage 3 logic: quotient correction, per-bank read addresses
	always_comb begin
		if (r_s3 >= W_A) begin
			wrow = q_s3 + AW'(1);
			wcol = r_s3 - W_A;
		end else begin
			wrow = q_s3;
			wcol = r_s3;
		end
		for (int b = 0; b < dwb_pkg::BANKS; b++) begin
			// even bank row or column steps past an odd source coordinate
			raddr[b] = ((b & 2) != 0 ? rb_s3 : rb_s3 + (py_s3 ? HW_BA : BA_W'(0)))
				+ BA_W'(cx_s3) + BA_W'((b & 1) == 0 && px_s3);
		end
	end

	// stage 4 logic: write address and bank request fan-out
	always_comb begin
		waddr = BA_W'(wrow_s4) * HW_BA + BA_W'(wcol_s4);
		for (int b = 0; b < dwb_pkg::BANKS; b++) begin
			bank_we[b] = valid_s4 && (act_s4 == dwb_pkg::ACT_WRITE) && wr_ok_s4
				&& (wbank_s4 == dwb_pkg::BSEL_W'(b));
			bank_addr[b] = (act_s4 == dwb_pkg::ACT_WRITE) ? waddr : raddr_s4[b];
		end
		bank_wdata   = value_s4;
		ctl.valid    = valid_s4;
		ctl.act      = act_s4;
		ctl.in_range = inside_s4;
		ctl.fx       = fx_s4;
		ctl.fy       = fy_s4;
		ctl.px       = px_s4;
		ctl.py       = py_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= action;
			addr_s1  <= texel_address;
			value_s1 <= texel_value;
			ox_s1    <= out_x;
			oy_s1    <= out_y;
			dx_s1    <= disp_x;
			dy_s1    <= disp_y;

			act_s2    <= act_s1;
			wr_ok_s2  <= wr_ok;
			addr_s2   <= addr_s1;
			value_s2  <= value_s1;
			qest_s2   <= prod_recip[PW-1:dwb_pkg::RECIP_SHIFT];
			sx_s2     <= sx;
			sy_s2     <= sy;
			inside_s2 <= in_range;
			fx_s2     <= dx_s1[FW-1:0];
			fy_s2     <= dy_s1[FW-1:0];

			act_s3    <= act_s2;
			wr_ok_s3  <= wr_ok_s2;
			value_s3  <= value_s2;
			q_s3      <= qest_s2;
			r_s3      <= rest;
			rb_s3     <= rb;
			cx_s3     <= CIDX_W'(sx_s2[CW-1:1]);
			px_s3     <= sx_s2[0];
			py_s3     <= sy_s2[0];
			inside_s3 <= inside_s2;
			fx_s3     <= fx_s2;
			fy_s3     <= fy_s2;

			act_s4    <= act_s3;
			wr_ok_s4  <= wr_ok_s3;
			value_s4  <= value_s3;
			wrow_s4   <= RIDX_W'(wrow >> 1);
			wcol_s4   <= CIDX_W'(wcol >> 1);
			wbank_s4  <= {wrow[0], wcol[0]};
			raddr_s4  <= raddr;
			px_s4     <= px_s3;
			py_s4     <= py_s3;
			inside_s4 <= inside_s3;
			fx_s4     <= fx_s3;
			fy_s4     <= fy_s3;
		end
	end

endmodule

/* src/dwb_blend.sv */
module dwb_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  dwb_pkg::mode_t               filter_mode,
	input  dwb_pkg::ctl_t                ctl,
	input  logic [dwb_pkg::TEXEL_W-1:0]  rdata [dwb_pkg::BANKS],
	output logic                         res_valid,
	output logic [dwb_pkg::TEXEL_W-1:0]  pixel,
	output logic                         inside_res
);

	localparam int NB = dwb_pkg::BANKS;
	localparam int NC = dwb_pkg::CHANS;
	localparam int CH = dwb_pkg::CHAN_W;

	logic [7:0]                   wx [2];
	logic [7:0]                   wy [2];
	logic [7:0]                   wfull [NB];

	dwb_pkg::ctl_t                ctl_s5;
	logic [dwb_pkg::WGT_W-1:0]    w_s5 [NB];

	logic [dwb_pkg::TEXEL_W-1:0]  t [NB];
	logic [dwb_pkg::PROD_W-1:0]   prod [NB][NC];

	dwb_pkg::ctl_t                ctl_s6;
	logic [dwb_pkg::PROD_W-1:0]   prod_s6 [NB][NC];
	logic [dwb_pkg::TEXEL_W-1:0]  t0_s6;

	logic [dwb_pkg::SUM_W-1:0]    sum [NC];
	logic [dwb_pkg::TEXEL_W-1:0]  blended;

	// corner weights (8-f) and f
	always_comb begin
		wx[0] = 8'(dwb_pkg::WEIGHT_ONE - {1'b0, ctl.fx});
		wx[1] = 8'(ctl.fx);
		wy[0] = 8'(dwb_pkg::WEIGHT_ONE - {1'b0, ctl.fy});
		wy[1] = 8'(ctl.fy);
		for (int k = 0; k < NB; k++) begin
			wfull[k] = wx[k & 1] * wy[(k >> 1) & 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl;
			ctl_s6 <= ctl_s5;
		end
	end

	// corner k sits in the bank whose parity differs from the source by k
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			t[k] = rdata[dwb_pkg::BSEL_W'(k) ^ {ctl_s5.py, ctl_s5.px}];
			for (int c = 0; c < NC; c++) begin
				prod[k][c] = t[k][c*CH +: CH] * w_s5[k];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			sum[c] = dwb_pkg::SUM_W'(prod_s6[0][c] + prod_s6[1][c]
				+ prod_s6[2][c] + prod_s6[3][c]);
		end
		blended = {dwb_pkg::ALPHA_OPAQUE,
			sum[2][dwb_pkg::BLEND_SHIFT +: CH],
			sum[1][dwb_pkg::BLEND_SHIFT +: CH],
			sum[0][dwb_pkg::BLEND_SHIFT +: CH]};
		res_valid  = ctl_s6.valid && (ctl_s6.act == dwb_pkg::ACT_RENDER);
		inside_res = ctl_s6.in_range;
		if (!ctl_s6.in_range) begin
			pixel = '0;
		end else if (filter_mode == dwb_pkg::MODE_BILINEAR) begin
			pixel = blended;
		end else begin
			pixel = t0_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NB; k++) begin
				w_s5[k] <= wfull[k][dwb_pkg::WGT_W-1:0];
			end
			prod_s6 <= prod;
			t0_s6   <= t[0];
		end
	end

endmodule

/* src/displacement_warp_bilinear.sv */
// channel     direction  payload (lowest bit first)
// s_axis_*    in         tuser: action; tdata: texel_address, texel_value, out_x,
//                        out_y, disp_x, disp_y, zero pad to 88 bits
// m_axis_*    out        tdata: pixel, inside_res, zero pad to 40 bits
// cfg_wr_*    in         filter_mode, written when cfg_wr_en is high
//
// one transaction per clock in both directions while the output does not stall; a render
// transaction's result is presented on m_axis after acceptance, a write transaction gives none
// the path runs through the address split (reciprocal multiply, remainder, correction),
// the registered read of the four parity banks and the two blend stages
// arst_n clears all valid bits, the output and the skid register; texture banks
// are not cleared and hold undefined data until written
// a stalled output fills the skid register, then the whole pipeline holds

module displacement_warp_bilinear #(
	parameter int IMAGE_WIDTH  = dwb_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = dwb_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// texel_address, texel_value, out_x, out_y, disp_x, disp_y, pad
	input  logic [dwb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action
	input  logic [0:0]                         s_axis_tuser,

	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// pixel, inside_res, pad
	output logic [dwb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data
);

	localparam int HW         = (IMAGE_WIDTH + 1) / 2;
	localparam int HH         = (IMAGE_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HW * HH;
	localparam int BA_W       = dwb_pkg::idx_w(BANK_DEPTH);
	localparam int TW         = dwb_pkg::TEXEL_W;

	// pipeline advances while the skid register is free
	logic                 en;
	logic                 in_valid;

	dwb_pkg::mode_t       filter_mode_q;

	dwb_pkg::ctl_t        ctl;
	logic [dwb_pkg::BANKS-1:0] bank_we;
	logic [BA_W-1:0]      bank_addr [dwb_pkg::BANKS];
	logic [TW-1:0]        bank_wdata;
	logic [TW-1:0]        bank_rdata [dwb_pkg::BANKS];

	logic                 res_valid;
	logic [TW-1:0]        res_pixel;
	logic                 res_inside;
	logic                 res_take;

	// output register and skid register
	logic                 out_valid_q;
	logic [TW-1:0]        out_pixel_q;
	logic                 out_inside_q;
	logic                 skid_valid_q;
	logic [TW-1:0]        skid_pixel_q;
	logic                 skid_inside_q;
	logic                 out_stalled;

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign in_valid      = s_axis_tvalid && en;
	assign res_take      = res_valid && en;
	assign out_stalled   = out_valid_q && !m_axis_tready;

	// mode register; the user must write it only while the block is idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= dwb_pkg::MODE_NEAREST;
		end else if (cfg_wr_en) begin
			filter_mode_q <= dwb_pkg::mode_t'(cfg_wr_data);
		end
	end

	// stages 1 to 4: coordinate math, address split, bank requests
	dwb_addr_pipe #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_addr (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.action        (dwb_pkg::action_t'(s_axis_tuser[0])),
		.texel_address (s_axis_tdata[dwb_pkg::IN_ADDR_LSB +: dwb_pkg::ADDR_W]),
		.texel_value   (s_axis_tdata[dwb_pkg::IN_VALUE_LSB +: TW]),
		.out_x         (s_axis_tdata[dwb_pkg::IN_OX_LSB +: dwb_pkg::OX_W]),
		.out_y         (s_axis_tdata[dwb_pkg::IN_OY_LSB +: dwb_pkg::OY_W]),
		.disp_x        ($signed(s_axis_tdata[dwb_pkg::IN_DX_LSB +: dwb_pkg::DISP_W])),
		.disp_y        ($signed(s_axis_tdata[dwb_pkg::IN_DY_LSB +: dwb_pkg::DISP_W])),
		.ctl           (ctl),
		.bank_we       (bank_we),
		.bank_addr     (bank_addr),
		.bank_wdata    (bank_wdata)
	);

	// stage 5: four texture banks, one per row and column parity, so every
	// 2x2 neighborhood reads each bank exactly once
	for (genvar b = 0; b < dwb_pkg::BANKS; b++) begin : g_bank
		dwb_tex_bank #(
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.en    (en),
			.we    (bank_we[b]),
			.addr  (bank_addr[b]),
			.wdata (bank_wdata),
			.rdata (bank_rdata[b])
		);
	end

	// stages 5 and 6: corner routing, weighting and channel sums
	dwb_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.filter_mode (filter_mode_q),
		.ctl         (ctl),
		.rdata       (bank_rdata),
		.res_valid   (res_valid),
		.pixel       (res_pixel),
		.inside_res  (res_inside)
	);

	// output side: a result arriving while the output stalls parks in the skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_stalled) begin
			if (res_take) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_take;
		end
	end

	always_ff @(posedge clk) begin
		if (out_stalled) begin
			if (res_take) begin
				skid_pixel_q  <= res_pixel;
				skid_inside_q <= res_inside;
			end
		end else if (skid_valid_q) begin
			out_pixel_q  <= skid_pixel_q;
			out_inside_q <= skid_inside_q;
		end else begin
			out_pixel_q  <= res_pixel;
			out_inside_q <= res_inside;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(dwb_pkg::OUT_TDATA_W - TW - 1){1'b0}}, out_inside_q, out_pixel_q};

endmodule

/* tb/displacement_warp_bilinear_checker.sv */
`timescale 1ns / 100ps

module displacement_warp_bilinear_checker #(
	parameter int IMAGE_WIDTH  = dwb_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = dwb_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [dwb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic [0:0]                         s_axis_tuser,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [dwb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	output int                                 pixel_errors,
	output int                                 pending_pixels
);
	import dwb_pkg::*;

	localparam int TEX_DEPTH    = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [TEXEL_W-1:0] pixel;
		logic               in_range;
	} warp_out_t;

	bit [TEXEL_W-1:0] texels [TEX_DEPTH];
	mode_t            filter_mode;
	warp_out_t        pixel_fifo [$];
	int               error_count = 0;

	function automatic logic [CHAN_W-1:0] blend_channel(input logic [TEXEL_W-1:0] t00, t01,
			t10, t11, input int fx, fy, sh);
		int unsigned wx0, wy0, acc;
		wx0 = int'(WEIGHT_ONE) - fx;
		wy0 = int'(WEIGHT_ONE) - fy;
		acc = t00[sh +: CHAN_W] * wx0 * wy0 + t01[sh +: CHAN_W] * fx * wy0
			+ t10[sh +: CHAN_W] * wx0 * fy + t11[sh +: CHAN_W] * fx * fy;
		return CHAN_W'(acc >> BLEND_SHIFT);
	endfunction

	function automatic warp_out_t warp_pixel(input logic [OX_W-1:0] ox, input logic [OY_W-1:0] oy,
			input logic signed [DISP_W-1:0] dx, dy);
		int sx, sy, base, fx, fy;
		logic [TEXEL_W-1:0] t00, t01, t10, t11;
		warp_out_t r;
		sx = int'(ox) + (int'(dx) >>> FRAC_W);
		sy = int'(oy) + (int'(dy) >>> FRAC_W);
		fx = int'(dx[FRAC_W-1:0]);
		fy = int'(dy[FRAC_W-1:0]);
		r = '0;
		if (sx < 0 || sx >= IMAGE_WIDTH - 1 || sy < 0 || sy >= IMAGE_HEIGHT - 1)
			return r;
		base = sy * IMAGE_WIDTH + sx;
		r.in_range = 1'b1;
		if (filter_mode == MODE_NEAREST) begin
			r.pixel = texels[base];
		end else begin
			t00 = texels[base];
			t01 = texels[base + 1];
			t10 = texels[base + IMAGE_WIDTH];
			t11 = texels[base + IMAGE_WIDTH + 1];
			r.pixel = {ALPHA_OPAQUE, blend_channel(t00, t01, t10, t11, fx, fy, 16),
				blend_channel(t00, t01, t10, t11, fx, fy, 8),
				blend_channel(t00, t01, t10, t11, fx, fy, 0)};
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		warp_out_t want;
		logic [TEXEL_W-1:0] got_pixel;
		logic got_inside;
		logic [ADDR_W-1:0] waddr;
		if (!arst_n) begin
			filter_mode <= MODE_NEAREST;
		end else begin
			if (cfg_wr_en)
				filter_mode <= mode_t'(cfg_wr_data);
			// retire first, so a stray output never pairs with a same-edge input
			if (m_axis_tvalid && m_axis_tready) begin
				got_pixel = m_axis_tdata[TEXEL_W-1:0];
				got_inside = m_axis_tdata[OUT_INSIDE_BIT];
				if (pixel_fifo.size() == 0) begin
					if (error_count < REPORT_LIMIT)
						$display("%0t: unexpected output transaction pixel %08h inside %0b",
							$realtime, got_pixel, got_inside);
					error_count++;
				end else begin
					want = pixel_fifo.pop_front();
					if (want.pixel !== got_pixel || want.in_range !== got_inside) begin
						if (error_count < REPORT_LIMIT)
							$display("%0t: pixel mismatch expected %08h inside %0b, got %08h inside %0b",
								$realtime, want.pixel, want.in_range, got_pixel, got_inside);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (action_t'(s_axis_tuser[0]) == ACT_WRITE) begin
					waddr = s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
					if (waddr < TEX_DEPTH)
						texels[waddr] = s_axis_tdata[IN_VALUE_LSB +: TEXEL_W];
				end else begin
					pixel_fifo.push_back(warp_pixel(s_axis_tdata[IN_OX_LSB +: OX_W],
						s_axis_tdata[IN_OY_LSB +: OY_W], s_axis_tdata[IN_DX_LSB +: DISP_W],
						s_axis_tdata[IN_DY_LSB +: DISP_W]));
				end
			end
		end
		pixel_errors <= error_count;
		pending_pixels <= pixel_fifo.size();
	end

endmodule

/* tb/displacement_warp_bilinear_test.sv */
`timescale 1ns / 100ps

module displacement_warp_bilinear_test;
	import dwb_pkg::*;

	// raster and store geometry, same as the block defaults
	localparam int IMG_W     = IMAGE_WIDTH_DEF;
	localparam int IMG_H     = IMAGE_HEIGHT_DEF;
	localparam int TEX_DEPTH = IMG_W * IMG_H;

	localparam int RESET_CYCLES  = 12;
	localparam int MAX_IDLE      = 13;
	// a write may still be in flight after the last pixel
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PATCHES       = 8;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 88;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// texel_address, texel_value, out_x, out_y, disp_x, disp_y, pad
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// action
	logic [0:0]             s_axis_tuser = '0;

	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// pixel, inside_res, pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	int pixel_errors;
	int pending_pixels;

	// texels the stimulus has written, so a render never reads an unwritten entry
	bit tex_written [TEX_DEPTH];

	// small written windows of the texture, corners plus a few interior spots
	int patch_x0 [PATCHES];
	int patch_y0 [PATCHES];
	int patch_size [PATCHES];

	// when set, both sides run back to back with no idle cycles
	bit no_gaps = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	displacement_warp_bilinear u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	displacement_warp_bilinear_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.pixel_errors   (pixel_errors),
		.pending_pixels (pending_pixels)
	);

	// one input transaction, preceded by a random idle stretch
	// valid is only lowered when a gap follows, so it never drops and rises in one step
	task automatic send_item(input action_t act, input logic [ADDR_W-1:0] addr,
			input logic [TEXEL_W-1:0] value, input logic [OX_W-1:0] ox,
			input logic [OY_W-1:0] oy, input logic [DISP_W-1:0] dx, dy);
		int gap;
		logic [IN_TDATA_W-1:0] word;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
		word = '0;
		word[IN_ADDR_LSB +: ADDR_W] = addr;
		word[IN_VALUE_LSB +: TEXEL_W] = value;
		word[IN_OX_LSB +: OX_W] = ox;
		word[IN_OY_LSB +: OY_W] = oy;
		word[IN_DX_LSB +: DISP_W] = dx;
		word[IN_DY_LSB +: DISP_W] = dy;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// texel write; the render fields carry noise the block must ignore
	task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [TEXEL_W-1:0] value);
		if (addr < TEX_DEPTH)
			tex_written[addr] = 1'b1;
		send_item(ACT_WRITE, addr, value, $urandom, $urandom, $urandom, $urandom);
	endtask

	// render with random noise in the write fields
	task automatic render(input logic [OX_W-1:0] ox, input logic [OY_W-1:0] oy,
			input logic [DISP_W-1:0] dx, dy);
		send_item(ACT_RENDER, $urandom, $urandom, ox, oy, dx, dy);
	endtask

	// true when the displaced source is outside or all four neighbors are written
	function automatic bit source_ready(input logic [OX_W-1:0] ox, input logic [OY_W-1:0] oy,
			input logic signed [DISP_W-1:0] dx, dy);
		int sx, sy, base;
		sx = int'(ox) + (int'(dx) >>> FRAC_W);
		sy = int'(oy) + (int'(dy) >>> FRAC_W);
		if (sx < 0 || sx >= IMG_W - 1 || sy < 0 || sy >= IMG_H - 1)
			return 1'b1;
		base = sy * IMG_W + sx;
		return tex_written[base] && tex_written[base + 1] && tex_written[base + IMG_W]
			&& tex_written[base + IMG_W + 1];
	endfunction

	// mostly random words, with all-zero and all-one texels mixed in
	function automatic logic [TEXEL_W-1:0] texel_word();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		return $urandom;
	endfunction

	// well-formed render: source square lies inside a written patch, random fraction
	task automatic render_in_patch();
		int p, sx, sy, ox, oy;
		logic signed [DISP_W-1:0] dx, dy;
		p = $urandom_range(0, PATCHES - 1);
		sx = $urandom_range(patch_x0[p], patch_x0[p] + patch_size[p] - 2);
		sy = $urandom_range(patch_y0[p], patch_y0[p] + patch_size[p] - 2);
		do begin
			dx = $urandom;
			ox = sx - (int'(dx) >>> FRAC_W);
		end while (ox < 0 || ox >= (1 << OX_W));
		do begin
			dy = $urandom;
			oy = sy - (int'(dy) >>> FRAC_W);
		end while (oy < 0 || oy >= (1 << OY_W));
		render(ox, oy, dx, dy);
	endtask

	// fully random render; pushed far right when it would hit unwritten texels
	task automatic render_noise();
		logic [OX_W-1:0] ox;
		logic [OY_W-1:0] oy;
		logic [DISP_W-1:0] dx, dy;
		ox = $urandom;
		oy = $urandom;
		dx = $urandom;
		dy = $urandom;
		if (!source_ready(ox, oy, dx, dy))
			ox[OX_W-1 -: 2] = 2'b11;
		render(ox, oy, dx, dy);
	endtask

	// sender pauses until every pixel is back and any write has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pixels != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// filter mode change, only with the pipeline empty
	task automatic set_mode(input mode_t m);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// raster edges, both ends of the displacement, out-of-range output coordinates
	task automatic edge_renders();
		render(0, 0, 8'h00, 8'h00);                  // origin
		render(IMG_W - 2, IMG_H - 2, 8'h00, 8'h00);  // last valid source
		render(IMG_W - 1, IMG_H - 2, 8'h00, 8'h00);  // one column past
		render(IMG_W - 2, IMG_H - 1, 8'h00, 8'h00);  // one row past
		render(0, 0, 8'hFF, 8'h00);                  // source column -1
		render(0, 0, 8'h00, 8'hFF);                  // source row -1
		render(16, 16, 8'h80, 8'h80);                // most negative shift onto origin
		render(IMG_W - 17, IMG_H - 17, 8'h7F, 8'h7F);// most positive shift, full fraction
		render(IMG_W + 8, 0, 8'h80, 8'h00);          // output column past raster, source inside
		render(0, IMG_H + 10, 8'h00, 8'h80);         // output row past raster, source inside
		render('1, '1, 8'h80, 8'h80);                // largest output coordinate
	endtask

	// watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// result side backpressure, one draw per output transaction
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int p, x, y, phase, n, pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_mode(MODE_NEAREST);

		// corner patches 8x8, interior patches 6x6 at random spots
		patch_x0[0] = 0;         patch_y0[0] = 0;
		patch_x0[1] = IMG_W - 8; patch_y0[1] = 0;
		patch_x0[2] = 0;         patch_y0[2] = IMG_H - 8;
		patch_x0[3] = IMG_W - 8; patch_y0[3] = IMG_H - 8;
		for (p = 0; p < PATCHES; p++) begin
			patch_size[p] = (p < 4) ? 8 : 6;
			if (p >= 4) begin
				patch_x0[p] = $urandom_range(0, IMG_W - 6);
				patch_y0[p] = $urandom_range(0, IMG_H - 6);
			end
		end
		for (p = 0; p < PATCHES; p++)
			for (y = 0; y < patch_size[p]; y++)
				for (x = 0; x < patch_size[p]; x++)
					write_texel((patch_y0[p] + y) * IMG_W + patch_x0[p] + x, texel_word());

		// directed: extreme texels at the corners, ignored writes past the store
		write_texel(0, '1);
		write_texel((IMG_H - 2) * IMG_W + IMG_W - 2, '0);
		write_texel(TEX_DEPTH, $urandom);
		write_texel('1, $urandom);
		edge_renders();
		set_mode(MODE_BILINEAR);
		edge_renders();

		// random phases, mode alternating, one phase without any idling
		for (phase = 0; phase < PHASES; phase++) begin
			set_mode((phase % 2 == 1) ? MODE_BILINEAR : MODE_NEAREST);
			no_gaps = (phase == 3);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					// refresh a texel inside a patch
					p = $urandom_range(0, PATCHES - 1);
					x = patch_x0[p] + $urandom_range(0, patch_size[p] - 1);
					y = patch_y0[p] + $urandom_range(0, patch_size[p] - 1);
					write_texel(y * IMG_W + x, texel_word());
				end else if (pick < 33) begin
					// any address, including past the store
					write_texel($urandom, $urandom);
				end else if (pick < 85) begin
					render_in_patch();
				end else begin
					render_noise();
				end
			end
		end
		no_gaps = 1'b0;

		settle();
		if (pixel_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
